// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: heap geometry, derived widths,
// header entry type, operation and status codes, and controller states.
// No dependencies.
package ffha_pkg;

    // Heap geometry (ALIGN_BYTES must be a power of two)
    localparam int unsigned HEAP_BYTES   = 48 * 1024;
    localparam int unsigned ALIGN_BYTES  = 8;
    localparam int unsigned HEADER_BYTES = 16;

    // Header rounded up to the alignment, and one header slot per granule
    localparam int unsigned HDR_BYTES = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                        * ALIGN_BYTES;
    localparam int unsigned GRANULES  = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int unsigned ALIGN_SH  = $clog2(ALIGN_BYTES);
    localparam int unsigned IDX_W     = $clog2(GRANULES);
    localparam int unsigned SZ_W      = $clog2(HEAP_BYTES + 1);

    // Byte address arithmetic width: covers block end past the heap and
    // a rounded request plus header and one granule
    localparam int unsigned ADR_W = $clog2(2 * HEAP_BYTES + 65536 + 2 * HDR_BYTES
                                           + 2 * ALIGN_BYTES);

    localparam logic [ADR_W-1:0] HEAP_A  = ADR_W'(HEAP_BYTES);
    localparam logic [ADR_W-1:0] HDR_A   = ADR_W'(HDR_BYTES);
    localparam logic [ADR_W-1:0] ALIGN_A = ADR_W'(ALIGN_BYTES);
    localparam logic [ADR_W-1:0] REM_A   = ADR_W'(ALIGN_BYTES - 1);
    localparam logic [ADR_W-1:0] GRAN_A  = ADR_W'(GRANULES);

    // Size of the single free block right after reset
    localparam logic [SZ_W-1:0] SZ_RESET = (HEAP_BYTES > HDR_BYTES) ?
                                           SZ_W'(HEAP_BYTES - HDR_BYTES) : '0;

    // Block header as stored per granule
    typedef struct packed {
        logic            used;
        logic [SZ_W-1:0] size;
    } t_hdr;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_NO_HEAP = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_A_CHK,
        S_A_WR,
        S_F_CHK,
        S_M_START,
        S_M_B,
        S_M_N,
        S_RESP
    } t_state;

endpackage

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator with split and coalesce over a header memory.
// A zero request or an address outside the heap is answered without reading a header;
// an allocate walks the blocks (with an extra write on split), a free walks to the matching
// payload and, on a hit, runs a merge pass over the chain. The walk reads one header per cycle.
// A new item is taken only once the last result registers; the unit waits in S_RESP on a stall.
// Synchronous active-low reset clears control; entry 0 reads as the whole free heap until written.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] request_bytes, [31:16] release_offset
    input  logic [0:0]  i_s_tuser,   // [0] func
    // Result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] payload_offset
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    // Header memory, one slot per granule
    t_hdr mem [GRANULES];

    t_state r_state, n_state;
    logic [ADR_W-1:0] r_need, n_need;
    logic [15:0]      r_rel, n_rel;
    logic [ADR_W-1:0] r_cur, n_cur;
    logic [ADR_W-1:0] r_nxt, n_nxt;
    logic [SZ_W-1:0]  r_bsz, n_bsz;
    logic             r_bused, n_bused;
    logic [15:0]      r_res_off, n_res_off;
    logic [1:0]       r_res_st, n_res_st;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_off, n_out_off;
    logic [1:0]       r_out_st, n_out_st;
    logic             r_w0, n_w0;
    logic             r_rd_ovr, n_rd_ovr;
    t_hdr             r_rd_data;

    // Memory port controls
    logic             rd_en;
    logic [ADR_W-1:0] rd_adr;
    logic [IDX_W-1:0] rd_idx;
    logic             we;
    logic [ADR_W-1:0] wr_adr;
    logic [IDX_W-1:0] wr_idx;
    t_hdr             wr_data;

    // Datapath helpers
    t_hdr             rd_hdr;
    logic [ADR_W-1:0] cur_sz;
    logic [ADR_W-1:0] cur_end;
    logic [ADR_W-1:0] nxt_end;
    logic [ADR_W-1:0] split_at;
    logic [ADR_W-1:0] merged;
    logic [ADR_W-1:0] merged_end;
    logic [ADR_W-1:0] req_ext;
    logic [ADR_W-1:0] rel_ext;
    logic             in_acc;
    logic             out_free;

    // Header as read; entry 0 holds its reset value until first written
    always_comb begin
        rd_hdr = r_rd_data;
        if (r_rd_ovr) begin
            rd_hdr.used = 1'b0;
            rd_hdr.size = SZ_RESET;
        end
    end

    assign cur_sz     = ADR_W'(rd_hdr.size);
    assign cur_end    = r_cur + HDR_A + cur_sz;
    assign nxt_end    = r_nxt + HDR_A + cur_sz;
    assign split_at   = r_cur + HDR_A + r_need;
    assign merged     = ADR_W'(r_bsz) + HDR_A + cur_sz;
    assign merged_end = r_cur + HDR_A + merged;
    assign req_ext    = ADR_W'(i_s_tdata[15:0]);
    assign rel_ext    = ADR_W'(r_rel);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign rd_idx     = rd_adr[ALIGN_SH +: IDX_W];
    assign wr_idx     = wr_adr[ALIGN_SH +: IDX_W];

    // Next state, memory controls and result
    always_comb begin
        n_state     = r_state;
        n_need      = r_need;
        n_rel       = r_rel;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_bsz       = r_bsz;
        n_bused     = r_bused;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        n_out_off   = r_out_off;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid && !i_m_tready;
        rd_en       = 1'b0;
        rd_adr      = '0;
        we          = 1'b0;
        wr_adr      = '0;
        wr_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_off = '0;
                    n_res_st  = ST_OK;
                    n_cur     = '0;
                    n_rel     = i_s_tdata[31:16];
                    if (i_s_tuser[0] == FUNC_ALLOC) begin
                        n_need = (req_ext + REM_A) & ~REM_A;
                        if (i_s_tdata[15:0] == 16'd0) begin
                            n_res_st = ST_FAIL;
                            n_state  = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_A_CHK;
                        end
                    end else begin
                        if (ADR_W'(i_s_tdata[31:16]) >= HEAP_A) begin
                            n_res_st = ST_NO_HEAP;
                            n_state  = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_F_CHK;
                        end
                    end
                end
            end

            // Walk the chain for the first free block that fits
            S_A_CHK: begin
                if (!rd_hdr.used && cur_sz >= r_need) begin
                    if (cur_sz >= r_need + HDR_A + ALIGN_A &&
                        (split_at >> ALIGN_SH) < GRAN_A) begin
                        we           = 1'b1;
                        wr_adr       = split_at;
                        wr_data.used = 1'b0;
                        wr_data.size = SZ_W'(cur_sz - r_need - HDR_A);
                        n_state      = S_A_WR;
                    end else begin
                        we           = 1'b1;
                        wr_adr       = r_cur;
                        wr_data.used = 1'b1;
                        wr_data.size = rd_hdr.size;
                        n_res_off    = 16'(r_cur + HDR_A);
                        n_state      = S_RESP;
                    end
                end else if (cur_end < HEAP_A) begin
                    rd_en  = 1'b1;
                    rd_adr = cur_end;
                    n_cur  = cur_end;
                end else begin
                    n_res_st = ST_FAIL;
                    n_state  = S_RESP;
                end
            end

            // Shrink the split block and mark it used
            S_A_WR: begin
                we           = 1'b1;
                wr_adr       = r_cur;
                wr_data.used = 1'b1;
                wr_data.size = SZ_W'(r_need);
                n_res_off    = 16'(r_cur + HDR_A);
                n_state      = S_RESP;
            end

            // Walk the chain for the block whose payload is addressed
            S_F_CHK: begin
                if (r_cur + HDR_A == rel_ext) begin
                    we           = 1'b1;
                    wr_adr       = r_cur;
                    wr_data.used = 1'b0;
                    wr_data.size = rd_hdr.size;
                    n_state      = S_M_START;
                end else if (r_cur + HDR_A > rel_ext) begin
                    n_state = S_RESP;
                end else if (cur_end < HEAP_A) begin
                    rd_en  = 1'b1;
                    rd_adr = cur_end;
                    n_cur  = cur_end;
                end else begin
                    n_state = S_RESP;
                end
            end

            // Restart at the heap base for the merge pass
            S_M_START: begin
                rd_en   = 1'b1;
                n_cur   = '0;
                n_state = S_M_B;
            end

            // Latch the base block, fetch its successor
            S_M_B: begin
                n_bsz   = rd_hdr.size;
                n_bused = rd_hdr.used;
                if (cur_end < HEAP_A) begin
                    rd_en   = 1'b1;
                    rd_adr  = cur_end;
                    n_nxt   = cur_end;
                    n_state = S_M_N;
                end else begin
                    n_state = S_RESP;
                end
            end

            // Absorb a free successor, or advance to it
            S_M_N: begin
                if (!r_bused && !rd_hdr.used) begin
                    we           = 1'b1;
                    wr_adr       = r_cur;
                    wr_data.used = 1'b0;
                    wr_data.size = SZ_W'(merged);
                    n_bsz        = SZ_W'(merged);
                    if (merged_end < HEAP_A) begin
                        rd_en  = 1'b1;
                        rd_adr = merged_end;
                        n_nxt  = merged_end;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_cur   = r_nxt;
                    n_bsz   = rd_hdr.size;
                    n_bused = rd_hdr.used;
                    if (nxt_end < HEAP_A) begin
                        rd_en  = 1'b1;
                        rd_adr = nxt_end;
                        n_nxt  = nxt_end;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end

            // Hand the result to the output register
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_off   = r_res_off;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_w0     = r_w0 || (we && wr_idx == '0);
        n_rd_ovr = rd_en && rd_idx == '0 && !r_w0 && !(we && wr_idx == '0);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w0        <= 1'b0;
            r_rd_ovr    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_w0        <= n_w0;
            r_rd_ovr    <= n_rd_ovr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_need    <= n_need;
        r_rel     <= n_rel;
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_bsz     <= n_bsz;
        r_bused   <= n_bused;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        r_out_off <= n_out_off;
        r_out_st  <= n_out_st;
    end

    // Header memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_off;
    assign o_m_tuser  = r_out_st;

endmodule

// ===== verif/tb_first_fit_heap_allocator_unit.sv =====
// Testbench for first_fit_heap_allocator_unit: directed table then random
// allocate/free traffic, checked against a behavioral heap predictor.
// Depends on rtl/ffha_pkg.sv and rtl/first_fit_heap_allocator_unit.sv.
module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned DRAIN_WAIT  = 400;
    localparam int unsigned RAND_ITEMS  = 650;
    localparam int unsigned LIVE_MAX    = 48;
    localparam int unsigned NUM_ROWS    = 25;

    // Result of one allocator request
    typedef struct packed {
        logic [15:0] offset;
        logic [1:0]  status;
    } t_alloc_reply;

    // One row of the directed table; fixed marks a typed-in expectation
    typedef struct packed {
        logic        func;
        logic [15:0] req;
        logic [15:0] rel;
        logic        fixed;
        logic [15:0] off;
        logic [1:0]  st;
    } t_row;

    localparam t_row PLAN [NUM_ROWS] = '{
        '{FUNC_ALLOC, 16'd0,     16'hFFFF, 1'b1, 16'd0,  ST_FAIL},    // zero request
        '{FUNC_ALLOC, 16'd49152, 16'h0000, 1'b1, 16'd0,  ST_FAIL},    // larger than heap
        '{FUNC_ALLOC, 16'd49136, 16'h5555, 1'b1, 16'd16, ST_OK},      // whole heap, no split
        '{FUNC_ALLOC, 16'd1,     16'hAAAA, 1'b1, 16'd0,  ST_FAIL},    // heap full
        '{FUNC_FREE,  16'hC000,  16'd16,   1'b1, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'h3FFF,  16'hFFFF, 1'b1, 16'd0,  ST_NO_HEAP}, // far outside
        '{FUNC_FREE,  16'd0,     16'd49152, 1'b1, 16'd0, ST_NO_HEAP}, // first byte outside
        '{FUNC_FREE,  16'd0,     16'd49151, 1'b1, 16'd0, ST_OK},      // not a payload
        '{FUNC_ALLOC, 16'd1,     16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd8,     16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd9,     16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd40000, 16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd40,   1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd40,   1'b0, 16'd0,  ST_OK},      // already free
        '{FUNC_FREE,  16'd0,     16'd0,    1'b0, 16'd0,  ST_OK},      // header, not payload
        '{FUNC_ALLOC, 16'd8,     16'd0,    1'b0, 16'd0,  ST_OK},      // exact fit into hole
        '{FUNC_ALLOC, 16'd16383, 16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd64,   1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd10,    16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd9040,  16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_ALLOC, 16'd1,     16'd0,    1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd96,   1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd40112, 1'b0, 16'd0, ST_OK},      // merge with previous
        '{FUNC_FREE,  16'd0,     16'd16,   1'b0, 16'd0,  ST_OK},
        '{FUNC_FREE,  16'd0,     16'd40,   1'b0, 16'd0,  ST_OK}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [15:0] request_bytes, [31:16] release_offset
    logic [0:0]  i_s_tuser  = '0;   // [0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [15:0] payload_offset
    logic [1:0]  o_m_tuser;         // [1:0] status

    // Predicted heap: block size and used mark per granule
    int unsigned  blk_size [GRANULES];
    bit           blk_used [GRANULES];
    t_alloc_reply alloc_reply_q [$];

    int unsigned fail_cnt    = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;

    int unsigned stall_tick = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_hold = 0;

    first_fit_heap_allocator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the predicted heap and return its reply
    function automatic t_alloc_reply heap_apply(input logic func, input logic [15:0] req,
                                                input logic [15:0] rel);
        t_alloc_reply r;
        int unsigned  need;
        int unsigned  b;
        int unsigned  n;
        int unsigned  sz;
        r.offset = '0;
        r.status = ST_OK;
        if (func == FUNC_ALLOC) begin
            if (req == 16'd0) begin
                r.status = ST_FAIL;
                return r;
            end
            need = ((int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            b = 0;
            while (b < HEAP_BYTES) begin
                sz = blk_size[b / ALIGN_BYTES];
                if (!blk_used[b / ALIGN_BYTES] && sz >= need) begin
                    // Split off the tail when it can hold a header and one granule
                    if (sz >= need + HDR_BYTES + ALIGN_BYTES) begin
                        n = b + HDR_BYTES + need;
                        blk_size[n / ALIGN_BYTES] = sz - need - HDR_BYTES;
                        blk_used[n / ALIGN_BYTES] = 1'b0;
                        blk_size[b / ALIGN_BYTES] = need;
                    end
                    blk_used[b / ALIGN_BYTES] = 1'b1;
                    r.offset = 16'(b + HDR_BYTES);
                    return r;
                end
                b = b + HDR_BYTES + sz;
            end
            r.status = ST_FAIL;
            return r;
        end
        if (int'(rel) >= HEAP_BYTES) begin
            r.status = ST_NO_HEAP;
            return r;
        end
        // Find the block whose payload starts at rel, stop once past it
        b = 0;
        while (b < HEAP_BYTES && b + HDR_BYTES <= int'(rel)) begin
            if (b + HDR_BYTES == int'(rel)) begin
                blk_used[b / ALIGN_BYTES] = 1'b0;
                // Merge every run of adjacent free blocks
                n = 0;
                while (n < HEAP_BYTES) begin
                    b = n + HDR_BYTES + blk_size[n / ALIGN_BYTES];
                    if (b >= HEAP_BYTES) break;
                    if (!blk_used[n / ALIGN_BYTES] && !blk_used[b / ALIGN_BYTES])
                        blk_size[n / ALIGN_BYTES] += HDR_BYTES + blk_size[b / ALIGN_BYTES];
                    else
                        n = b;
                end
                break;
            end
            b = b + HDR_BYTES + blk_size[b / ALIGN_BYTES];
        end
        return r;
    endfunction

    // Present one item in bursts with random gaps, return once accepted
    task automatic send_item(input logic func, input logic [15:0] req,
                             input logic [15:0] rel);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {rel, req};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stall the result channel on a changing pattern
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_m_tready <= (stall_tick % 4 == 3);
            end
            default: begin
                if (stall_hold != 0) begin
                    i_m_tready <= 1'b0;
                    stall_hold <= stall_hold - 1;
                end else begin
                    i_m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_hold <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Check each result item against the oldest prediction; watch for a hang
    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                if (alloc_reply_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: offset %0d status %0d",
                                 o_m_tdata, o_m_tuser);
                end else begin
                    want = alloc_reply_q.pop_front();
                    if (o_m_tdata !== want.offset || o_m_tuser !== want.status) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: offset exp %0d got %0d, status exp %0d got %0d",
                                     want.offset, o_m_tdata, want.status, o_m_tuser);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_first_fit_heap_allocator_unit: errors");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random traffic
    initial begin
        t_alloc_reply exp_r;
        int unsigned  live_off [$];
        int unsigned  live_sz [$];
        int unsigned  freed_off [$];
        int unsigned  last_freed_sz;
        int unsigned  pick;
        int unsigned  sel;
        logic         func;
        logic [15:0]  req;
        logic [15:0]  rel;
        logic         from_live;

        foreach (blk_size[g]) begin
            blk_size[g] = 0;
            blk_used[g] = 1'b0;
        end
        blk_size[0]   = HEAP_BYTES - HDR_BYTES;
        last_freed_sz = 64;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_item(PLAN[i].func, PLAN[i].req, PLAN[i].rel);
            exp_r = heap_apply(PLAN[i].func, PLAN[i].req, PLAN[i].rel);
            if (PLAN[i].fixed) begin
                exp_r.offset = PLAN[i].off;
                exp_r.status = PLAN[i].st;
            end
            alloc_reply_q.push_back(exp_r);
        end

        // Random traffic: mostly frees of live blocks and allocations
        for (int i = 0; i < RAND_ITEMS; i++) begin
            from_live = 1'b0;
            sel = $urandom_range(0, 99);
            if (live_off.size() == 0 || (sel < 45 && live_off.size() < LIVE_MAX)) begin
                func = FUNC_ALLOC;
                rel  = 16'($urandom);
                sel  = $urandom_range(0, 99);
                if (sel < 60)
                    req = 16'($urandom_range(1, 256));
                else if (sel < 75)
                    req = 16'((last_freed_sz > 20) ? last_freed_sz - $urandom_range(0, 20)
                                                   : $urandom_range(1, last_freed_sz));
                else if (sel < 85)
                    req = 16'($urandom_range(257, 4096));
                else if (sel < 95)
                    req = 16'($urandom_range(4097, 49152));
                else
                    case ($urandom_range(0, 2))
                        0: req = 16'd0;
                        1: req = 16'd49152;
                        default: req = 16'd49136;
                    endcase
            end else if (sel < 85) begin
                // Free a live block
                func = FUNC_FREE;
                req  = 16'($urandom_range(0, 49152));
                pick = $urandom_range(0, live_off.size() - 1);
                rel  = 16'(live_off[pick]);
                last_freed_sz = live_sz[pick];
                live_off.delete(pick);
                live_sz.delete(pick);
                from_live = 1'b1;
            end else begin
                // Noise: stray offsets, double frees, outside the heap
                func = FUNC_FREE;
                req  = 16'($urandom_range(0, 49152));
                sel  = $urandom_range(0, 2);
                if (sel == 0 && freed_off.size() != 0)
                    rel = 16'(freed_off[$urandom_range(0, freed_off.size() - 1)]);
                else if (sel == 1)
                    rel = 16'($urandom_range(0, HEAP_BYTES - 1));
                else
                    rel = 16'($urandom_range(HEAP_BYTES, 65535));
            end

            send_item(func, req, rel);
            exp_r = heap_apply(func, req, rel);
            alloc_reply_q.push_back(exp_r);

            // Track live blocks from the predicted replies
            if (func == FUNC_ALLOC && exp_r.status == ST_OK) begin
                live_off.push_back(int'(exp_r.offset));
                live_sz.push_back(((int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
            end
            if (from_live) begin
                freed_off.push_back(int'(rel));
                if (freed_off.size() > 16)
                    void'(freed_off.pop_front());
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then let the block settle
        while (alloc_reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("tb_first_fit_heap_allocator_unit: clean");
        else
            $display("tb_first_fit_heap_allocator_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_unit.sv
verif/tb_first_fit_heap_allocator_unit.sv
